FILE: rtl/fwesm_pkg.sv
// Shared types and constants for the four-wheel encoder speed meter.
`timescale 1ns / 1ps

package fwesm_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int PULSES_DEF   = 4;

  localparam int CH_FIELD_W = 2;
  localparam int TV_W       = 16;
  localparam int MASK_W     = 4;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int PERIOD_W   = 34;
  localparam int SPEED_W    = 25;
  localparam int DIST_W     = 32;
  localparam int DIV_W      = 38;
  localparam int DIV_CNT_W  = 6;

  localparam int IN_DATA_W   = 24;
  localparam int IN_USER_W   = 1;
  localparam int OUT_DATA_W  = 64;
  localparam int OUT_USER_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_EN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 2'd2;

  localparam logic [MASK_W-1:0] POLARITY_RST = 4'd9;
  localparam logic [MASK_W-1:0] DIST_EN_RST  = 4'd10;
  localparam logic [TV_W-1:0]   WEIGHT_RST   = 16'd499;

  localparam logic [DIV_W-1:0] SPEED_NUM     = DIV_W'(409_600_000);
  localparam logic [DIV_W-1:0] SPEED_DEN_MUL = DIV_W'(33);

  typedef struct packed {
    logic capture;
    logic eval;
    logic prep;
    logic load;
    logic step;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic is_final;
    logic period_pos;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/fwesm_ctrl.sv
// Controller state machine sequencing capture, update, divide and delivery.
`timescale 1ns / 1ps

module fwesm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fwesm_pkg::sts_t   sts,
  output fwesm_pkg::cmd_t   cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_PREP = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.is_final ? ST_PREP : ST_FIN;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.period_pos ? ST_LOAD : ST_FIN;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.deliver = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

FILE: rtl/fwesm_div.sv
// Serial restoring divider producing the rounded speed magnitude, one bit per cycle.
`timescale 1ns / 1ps

module fwesm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic                        step,
  input  logic [fwesm_pkg::DIV_W-1:0] den_i,
  output logic [fwesm_pkg::DIV_W-1:0] quot_o,
  output logic                        last_o
);

  localparam int W  = fwesm_pkg::DIV_W;
  localparam int CW = fwesm_pkg::DIV_CNT_W;

  logic [W-1:0]  rem_r, acc_r, den_r;
  logic [CW-1:0] cnt_r;
  logic [W:0]    rem_sh;
  logic [W+1:0]  diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem_r, acc_r[W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = !diff[W+1];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r <= fwesm_pkg::SPEED_NUM + (den_i >> 1);
      rem_r <= '0;
      den_r <= den_i;
    end else if (step) begin
      rem_r <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      acc_r <= {acc_r[W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign quot_o = acc_r;
  assign last_o = (cnt_r == CW'(W - 1));

endmodule

FILE: rtl/fwesm_dp.sv
// Datapath: configuration, per-channel state, period, divider and output register.
`timescale 1ns / 1ps

module fwesm_dp #(
  parameter int CHANNELS           = fwesm_pkg::CHANNELS_DEF,
  parameter int PULSES_PER_MEASURE = fwesm_pkg::PULSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fwesm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fwesm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                             it_mode,
  input  logic [fwesm_pkg::CH_FIELD_W-1:0] it_ch,
  input  logic                             it_pin,
  input  logic [fwesm_pkg::TV_W-1:0]       it_tv,
  input  fwesm_pkg::cmd_t                  cmd,
  output fwesm_pkg::sts_t                  sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [fwesm_pkg::CH_FIELD_W-1:0] out_ch,
  output logic                             out_speed_valid,
  output logic [fwesm_pkg::SPEED_W-1:0]    out_speed,
  output logic                             out_perr,
  output logic [fwesm_pkg::DIST_W-1:0]     out_dist
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int XW    = IDX_W + fwesm_pkg::CH_FIELD_W;
  localparam int PH_W  = $clog2(PULSES_PER_MEASURE);
  localparam int TV_W  = fwesm_pkg::TV_W;
  localparam int PW    = fwesm_pkg::PERIOD_W;
  localparam int SW    = fwesm_pkg::SPEED_W;
  localparam int DW    = fwesm_pkg::DIST_W;
  localparam int VW    = fwesm_pkg::DIV_W;
  localparam int MW    = fwesm_pkg::MASK_W;

  logic [MW-1:0]   cfg_pol_r, cfg_den_r;
  logic [TV_W-1:0] cfg_weight_r;

  logic                              it_mode_r, it_pin_r;
  logic [fwesm_pkg::CH_FIELD_W-1:0]  it_ch_r;
  logic [TV_W-1:0]                   it_tv_r;

  logic [PH_W-1:0] phase_r [CHANNELS];
  logic [TV_W-1:0] start_r [CHANNELS];
  logic [TV_W-1:0] ovf_r   [CHANNELS];
  logic            last_r  [CHANNELS];
  logic [DW-1:0]   dist_r  [CHANNELS];

  logic [XW-1:0]     ch_ext;
  logic [IDX_W-1:0]  idx;
  logic              exists, edge_hit, last_pulse, fwd_now, last_sel;
  logic [PH_W-1:0]   phase_sel;
  logic [TV_W-1:0]   start_sel, ovf_sel;
  logic [DW-1:0]     dist_sel, dist_step;
  logic [2*TV_W-1:0] prod;
  logic [PW-1:0]     period_nxt;

  logic [PW-1:0] period_r;
  logic [VW-1:0] den_r;
  logic          res_valid_r, res_perr_r, res_neg_r;
  logic [fwesm_pkg::CH_FIELD_W-1:0] res_ch_r;
  logic [DW-1:0] res_dist_r;

  logic [VW-1:0] quot;
  logic          div_last;
  logic [SW-1:0] mag;
  logic          period_pos;

  logic          out_valid_r, out_sv_r, out_perr_r;
  logic [fwesm_pkg::CH_FIELD_W-1:0] out_ch_r;
  logic [SW-1:0] out_speed_r;
  logic [DW-1:0] out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pol_r    <= fwesm_pkg::POLARITY_RST;
      cfg_den_r    <= fwesm_pkg::DIST_EN_RST;
      cfg_weight_r <= fwesm_pkg::WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fwesm_pkg::CFG_POLARITY: cfg_pol_r    <= cfg_wdata[MW-1:0];
        fwesm_pkg::CFG_DIST_EN:  cfg_den_r    <= cfg_wdata[MW-1:0];
        fwesm_pkg::CFG_WEIGHT:   cfg_weight_r <= cfg_wdata[TV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode_r <= it_mode;
      it_ch_r   <= it_ch;
      it_pin_r  <= it_pin;
      it_tv_r   <= it_tv;
    end
  end

  always_comb begin
    ch_ext     = {{IDX_W{1'b0}}, it_ch_r};
    idx        = ch_ext[IDX_W-1:0];
    exists     = (ch_ext < XW'(CHANNELS));
    edge_hit   = it_mode_r && exists;
    phase_sel  = exists ? phase_r[idx] : '0;
    start_sel  = exists ? start_r[idx] : '0;
    ovf_sel    = exists ? ovf_r[idx]   : '0;
    dist_sel   = exists ? dist_r[idx]  : '0;
    last_sel   = exists ? last_r[idx]  : 1'b1;
    last_pulse = (phase_sel == PH_W'(PULSES_PER_MEASURE - 1));
    fwd_now    = (it_pin_r == cfg_pol_r[it_ch_r]);
    if (cfg_den_r[it_ch_r]) begin
      dist_step = last_sel ? dist_sel + DW'(1) : dist_sel - DW'(1);
    end else begin
      dist_step = dist_sel;
    end
    prod       = (2*TV_W)'(ovf_sel) * (2*TV_W)'(cfg_weight_r);
    period_nxt = PW'(prod) + PW'(it_tv_r) - PW'(start_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        phase_r[c] <= '0;
        start_r[c] <= '0;
        ovf_r[c]   <= '0;
        last_r[c]  <= 1'b1;
        dist_r[c]  <= '0;
      end
    end else if (cmd.eval) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (!it_mode_r) begin
          ovf_r[c] <= ovf_r[c] + TV_W'(1);
        end else if (edge_hit && idx == IDX_W'(c)) begin
          if (phase_sel == '0) begin
            start_r[c] <= it_tv_r;
            ovf_r[c]   <= '0;
          end
          phase_r[c] <= last_pulse ? '0 : phase_sel + PH_W'(1);
          last_r[c]  <= fwd_now;
          dist_r[c]  <= dist_step;
        end
      end
    end
  end

  assign period_pos = !period_r[PW-1] && (period_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_ch_r    <= it_ch_r;
      res_neg_r   <= !fwd_now;
      res_valid_r <= 1'b0;
      res_perr_r  <= 1'b0;
      period_r    <= period_nxt;
      if (!exists) begin
        res_dist_r <= '0;
      end else if (it_mode_r) begin
        res_dist_r <= dist_step;
      end else begin
        res_dist_r <= dist_sel;
      end
    end else if (cmd.prep) begin
      res_valid_r <= period_pos;
      res_perr_r  <= !period_pos;
      den_r       <= VW'(period_r[PW-2:0]) * fwesm_pkg::SPEED_DEN_MUL;
    end
  end

  fwesm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (cmd.load),
    .step   (cmd.step),
    .den_i  (den_r),
    .quot_o (quot),
    .last_o (div_last)
  );

  assign mag = quot[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_ch_r   <= res_ch_r;
      out_sv_r   <= res_valid_r;
      out_perr_r <= res_perr_r;
      out_dist_r <= res_dist_r;
      if (!res_valid_r) begin
        out_speed_r <= '0;
      end else if (res_neg_r) begin
        out_speed_r <= SW'(0) - mag;
      end else begin
        out_speed_r <= mag;
      end
    end
  end

  always_comb begin
    sts.is_final   = edge_hit && last_pulse;
    sts.period_pos = period_pos;
    sts.div_last   = div_last;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_ch          = out_ch_r;
  assign out_speed_valid = out_sv_r;
  assign out_speed       = out_speed_r;
  assign out_perr        = out_perr_r;
  assign out_dist        = out_dist_r;

endmodule

FILE: rtl/four_wheel_encoder_speed_meter_core.sv
// Top level of the four-wheel encoder speed meter.
//
// Input stream: in_tuser carries the item kind (0 timer overflow tick,
// 1 encoder edge); in_tdata carries channel, direction pin and timer value.
// Every accepted item yields exactly one result on the output stream:
// channel, signed Q8 speed and distance count in out_tdata, speed-valid and
// period-error flags in out_tuser.
// Configuration: pulse cfg_we with cfg_index/cfg_wdata while the block is
// idle (0 polarity mask, 1 distance enable mask, 2 overflow weight).
// Flow: one item at a time; in_tready is high only when idle.
// A tick, a non-final edge or a final edge with a non-positive period
// skips the serial divider. The edge that ends a measurement group
// runs the serial divider, one quotient bit per cycle over 38 bits.
// Reset: synchronous, active low; clears all channel state, restores the
// configuration defaults and empties the output register.
// Stall: a result waits in the output register; the next item is still
// taken and processed, and delivery holds until the register is free.
`timescale 1ns / 1ps

module four_wheel_encoder_speed_meter_core #(
  parameter int CHANNELS           = fwesm_pkg::CHANNELS_DEF,
  parameter int PULSES_PER_MEASURE = fwesm_pkg::PULSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fwesm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fwesm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] channel, [2] direction_pin, [18:3] timer_value, [23:19] zero
  input  logic [fwesm_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic [fwesm_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] out_channel, [26:2] speed_q8, [58:27] distance, [63:59] zero
  output logic [fwesm_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] speed_valid, [1] period_error
  output logic [fwesm_pkg::OUT_USER_W-1:0] out_tuser
);

  localparam int CW = fwesm_pkg::CH_FIELD_W;
  localparam int TW = fwesm_pkg::TV_W;
  localparam int SW = fwesm_pkg::SPEED_W;
  localparam int DW = fwesm_pkg::DIST_W;

  fwesm_pkg::cmd_t cmd;
  fwesm_pkg::sts_t sts;

  logic          o_sv, o_perr;
  logic [CW-1:0] o_ch;
  logic [SW-1:0] o_speed;
  logic [DW-1:0] o_dist;

  fwesm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fwesm_dp #(
    .CHANNELS           (CHANNELS),
    .PULSES_PER_MEASURE (PULSES_PER_MEASURE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .it_mode         (in_tuser[0]),
    .it_ch           (in_tdata[CW-1:0]),
    .it_pin          (in_tdata[CW]),
    .it_tv           (in_tdata[CW+TW:CW+1]),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_ch          (o_ch),
    .out_speed_valid (o_sv),
    .out_speed       (o_speed),
    .out_perr        (o_perr),
    .out_dist        (o_dist)
  );

  assign out_tdata = {{(fwesm_pkg::OUT_DATA_W - CW - SW - DW){1'b0}}, o_dist, o_speed, o_ch};
  assign out_tuser = {o_perr, o_sv};

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is still in progress");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("speed valid and period error both set");

  a_speed_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[26:2] == '0))
    else $error("nonzero speed on a result without a valid speed");

  a_deliver_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deliver |-> (!out_tvalid || out_tready))
    else $error("result delivered over an untaken result");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the four-wheel encoder speed meter core.
`timescale 1ns / 1ps

module testbench;

  localparam logic MODE_TICK      = 1'b0;
  localparam logic MODE_EDGE      = 1'b1;
  localparam int   WHEELS         = 4;
  localparam int   EDGES_PER_SPAN = 4;
  localparam int   WATCHDOG_LIMIT = 3000;
  localparam int   SETTLE_CYCLES  = 60;
  localparam int   PHASE_ITEMS    = 200;
  localparam int   NUM_PHASES     = 7;
  localparam longint SPEED_Q8_NUM = 409_600_000;
  localparam longint PERIOD_SCALE = 33;

  class tacho_scoreboard;
    typedef struct packed {
      logic [1:0]  ch;
      logic        valid;
      logic [24:0] speed;
      logic        perr;
      logic [31:0] distance;
    } wheel_result_t;

    logic [3:0]  polarity;
    logic [3:0]  dist_en;
    logic [15:0] weight;
    logic [1:0]  edge_phase[WHEELS];
    logic [15:0] span_start[WHEELS];
    logic [15:0] ovf_cnt[WHEELS];
    logic        fwd_last[WHEELS];
    logic [31:0] dist_cnt[WHEELS];
    wheel_result_t expected_results[$];
    int errors;

    function new();
      polarity = fwesm_pkg::POLARITY_RST;
      dist_en  = fwesm_pkg::DIST_EN_RST;
      weight   = fwesm_pkg::WEIGHT_RST;
      for (int c = 0; c < WHEELS; c++) begin
        edge_phase[c] = '0;
        span_start[c] = '0;
        ovf_cnt[c]    = '0;
        fwd_last[c]   = 1'b1;
        dist_cnt[c]   = '0;
      end
      errors = 0;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        fwesm_pkg::CFG_POLARITY: polarity = val[3:0];
        fwesm_pkg::CFG_DIST_EN:  dist_en  = val[3:0];
        fwesm_pkg::CFG_WEIGHT:   weight   = val;
        default: ;
      endcase
    endfunction

    function void note_item(logic mode, logic [1:0] ch, logic pin, logic [15:0] tv);
      wheel_result_t r;
      logic fwd;
      int unsigned n;
      longint period, den, mag;
      r = '0;
      r.ch = ch;
      if (mode == MODE_TICK) begin
        for (int c = 0; c < WHEELS; c++) ovf_cnt[c] = ovf_cnt[c] + 16'd1;
        r.distance = dist_cnt[ch];
      end else begin
        n = edge_phase[ch] + 1;
        fwd = (pin == polarity[ch]);
        if (dist_en[ch]) dist_cnt[ch] = dist_cnt[ch] + (fwd_last[ch] ? 32'd1 : 32'hFFFF_FFFF);
        fwd_last[ch] = fwd;
        if (n == 1) begin
          span_start[ch] = tv;
          ovf_cnt[ch] = '0;
        end
        if (n >= EDGES_PER_SPAN) begin
          period = longint'(ovf_cnt[ch]) * longint'(weight) + longint'(tv)
                 - longint'(span_start[ch]);
          if (period <= 0) begin
            r.perr = 1'b1;
          end else begin
            den = PERIOD_SCALE * period;
            mag = (SPEED_Q8_NUM + den / 2) / den;
            r.valid = 1'b1;
            r.speed = 25'(fwd ? mag : -mag);
          end
          edge_phase[ch] = '0;
        end else begin
          edge_phase[ch] = 2'(n);
        end
        r.distance = dist_cnt[ch];
      end
      expected_results.push_back(r);
    endfunction

    function void flag_field(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [63:0] data, logic [1:0] user);
      wheel_result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %0h/%0h", $time, data, user);
        return;
      end
      e = expected_results.pop_front();
      if (data[1:0] !== e.ch)         flag_field("out_channel", e.ch, data[1:0]);
      if (user[0] !== e.valid)        flag_field("speed_valid", e.valid, user[0]);
      if (data[26:2] !== e.speed)     flag_field("speed_q8", e.speed, data[26:2]);
      if (user[1] !== e.perr)         flag_field("period_error", e.perr, user[1]);
      if (data[58:27] !== e.distance) flag_field("distance", e.distance, data[58:27]);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [fwesm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fwesm_pkg::CFG_W-1:0]      cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [fwesm_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [fwesm_pkg::IN_USER_W-1:0]  in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [fwesm_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [fwesm_pkg::OUT_USER_W-1:0] out_tuser;

  tacho_scoreboard board;
  logic quiet;
  int   rx_hold;
  int   stuck_cycles;
  int   timer_now;
  logic [3:0] pin_last;

  four_wheel_encoder_speed_meter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin : rx_stall
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold <= 0;
    end else if (out_tvalid && out_tready) begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      out_tready <= (stall == 0);
      rx_hold <= stall;
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold <= 0;
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        board.note_item(in_tuser[0], in_tdata[1:0], in_tdata[2], in_tdata[18:3]);
      if (out_tvalid && out_tready)
        board.check_result(out_tdata, out_tuser);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_item(input logic mode, input logic [1:0] ch, input logic pin,
                           input logic [15:0] tv);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {5'd0, tv, pin, ch};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    board.apply_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] pol, input logic [3:0] den,
                            input logic [15:0] w);
    program_reg(fwesm_pkg::CFG_POLARITY, {12'd0, pol});
    program_reg(fwesm_pkg::CFG_DIST_EN, {12'd0, den});
    program_reg(fwesm_pkg::CFG_WEIGHT, w);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_item();
    int roll;
    logic [1:0] ch;
    logic pin;
    logic [15:0] tv;
    timer_now = (timer_now + $urandom_range(0, 1500)) % 65536;
    roll = $urandom_range(0, 99);
    ch = 2'($urandom_range(0, 3));
    if (roll < 12) begin
      send_item(MODE_TICK, ch, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    end else begin
      pin = ($urandom_range(0, 9) == 0) ? ~pin_last[ch] : pin_last[ch];
      pin_last[ch] = pin;
      roll = $urandom_range(0, 99);
      if (roll < 80)      tv = timer_now[15:0];
      else if (roll < 92) tv = 16'($urandom_range(0, 65535));
      else if (roll < 96) tv = 16'h0000;
      else                tv = 16'hFFFF;
      send_item(MODE_EDGE, ch, pin, tv);
    end
  endtask

  initial begin
    board = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    quiet = 1'b0;
    timer_now = 0;
    pin_last = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ticks, then one span per wheel: wrapped timer, shortest period, zero and negative period
    send_item(MODE_TICK, 2'd0, 1'b1, 16'hFFFF);
    send_item(MODE_TICK, 2'd3, 1'b0, 16'h0000);
    send_item(MODE_EDGE, 2'd1, 1'b0, 16'd0);
    send_item(MODE_TICK, 2'd2, 1'b1, 16'h5A5A);
    send_item(MODE_EDGE, 2'd1, 1'b1, 16'hFFFF);
    send_item(MODE_EDGE, 2'd1, 1'b0, 16'd300);
    send_item(MODE_EDGE, 2'd1, 1'b1, 16'd1);
    send_item(MODE_EDGE, 2'd0, 1'b0, 16'd1000);
    send_item(MODE_EDGE, 2'd0, 1'b1, 16'd5);
    send_item(MODE_EDGE, 2'd0, 1'b0, 16'd7);
    send_item(MODE_EDGE, 2'd0, 1'b1, 16'd1001);
    send_item(MODE_EDGE, 2'd2, 1'b1, 16'hFFFF);
    send_item(MODE_EDGE, 2'd2, 1'b0, 16'hFFFF);
    send_item(MODE_EDGE, 2'd2, 1'b1, 16'hFFFF);
    send_item(MODE_EDGE, 2'd2, 1'b0, 16'hFFFF);
    send_item(MODE_EDGE, 2'd3, 1'b0, 16'hFFFF);
    send_item(MODE_EDGE, 2'd3, 1'b1, 16'h8000);
    send_item(MODE_EDGE, 2'd3, 1'b1, 16'h0001);
    send_item(MODE_EDGE, 2'd3, 1'b0, 16'h0000);

    // zero overflow weight: ticks add nothing to the period
    drain_results();
    set_config(fwesm_pkg::POLARITY_RST, fwesm_pkg::DIST_EN_RST, 16'd0);
    send_item(MODE_EDGE, 2'd1, 1'b1, 16'd10);
    send_item(MODE_TICK, 2'd1, 1'b0, 16'd0);
    send_item(MODE_TICK, 2'd0, 1'b1, 16'd0);
    send_item(MODE_EDGE, 2'd1, 1'b1, 16'd12);
    send_item(MODE_EDGE, 2'd1, 1'b0, 16'd15);
    send_item(MODE_EDGE, 2'd1, 1'b0, 16'd20);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: set_config(4'hF, 4'hF, 16'hFFFF);
        1: set_config(4'h0, 4'h0, 16'd1);
        2: set_config(4'($urandom_range(0, 15)), 4'hF, fwesm_pkg::WEIGHT_RST);
        default: set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            16'($urandom_range(0, 65535)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        quiet = (p == 3) || (i >= 60 && i < 90);
        if (p == 2 && i == 100) drain_results();
        send_random_item();
      end
    end

    drain_results();
    if (board.expected_results.size() != 0)
      $display("%0t missing results: expected %0d more, actual 0",
               $time, board.expected_results.size());
    if (board.errors == 0 && board.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fwesm_pkg.sv
rtl/fwesm_ctrl.sv
rtl/fwesm_div.sv
rtl/fwesm_dp.sv
rtl/four_wheel_encoder_speed_meter_core.sv
test/testbench.sv
